>>> rtl/core/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and field widths of the keyed set table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 31;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned EntryW  = KeyW + HandleW;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KST_IDLE,
    KST_SEARCH,
    KST_MOVE_RD,
    KST_MOVE_WR,
    KST_POP_DATA,
    KST_RESULT
  } state_e;

  typedef struct packed {
    status_e                status;
    logic                   found;
    logic [KeyW-1:0]        key;
    logic [HandleW-1:0]     handle;
    logic [CountW-1:0]      count;
  } result_t;

endpackage

>>> rtl/core/kst_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kst_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 47
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/kst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl
// Operation sequencer: linear key scan, compaction on remove, pop, add.
// ----------------------------------------------------------------------------
module kst_ctrl #(
  parameter int unsigned Capacity = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kst_pkg::OpW-1:0]     opcode_i,
  input  logic [kst_pkg::KeyW-1:0]    key_id_i,
  input  logic [kst_pkg::HandleW-1:0] entry_handle_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output kst_pkg::result_t            res_o,
  output logic                        rd_en_o,
  output logic [$clog2(Capacity)-1:0] rd_addr_o,
  input  logic [kst_pkg::EntryW-1:0]  rd_data_i,
  output logic                        wr_en_o,
  output logic [$clog2(Capacity)-1:0] wr_addr_o,
  output logic [kst_pkg::EntryW-1:0]  wr_data_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned OW = $clog2(Capacity + 1);

  kst_pkg::state_e state_q, state_d;
  logic [OW-1:0]   occ_q, occ_d;
  logic [OW-1:0]   scan_q, scan_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  logic [AW-1:0]   slot_q, slot_d;
  kst_pkg::op_e    op_q, op_d;
  logic [kst_pkg::KeyW-1:0]    key_q, key_d;
  logic [kst_pkg::HandleW-1:0] handle_q, handle_d;
  kst_pkg::result_t            res_q, res_d;

  logic [OW-1:0]               last_w;
  logic [kst_pkg::KeyW-1:0]    rd_key;
  logic [kst_pkg::HandleW-1:0] rd_handle;
  logic                        hit;
  logic                        miss;

  assign last_w    = occ_q - OW'(1);
  assign rd_key    = rd_data_i[kst_pkg::EntryW-1:kst_pkg::HandleW];
  assign rd_handle = rd_data_i[kst_pkg::HandleW-1:0];
  assign hit       = rd_vld_q && (rd_key == key_q);
  // miss once the last occupied slot was compared, or right away on an empty set
  assign miss      = !hit && ((occ_q == '0) || (rd_vld_q && (OW'(rd_idx_q) == last_w)));

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    scan_d    = scan_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    slot_d    = slot_q;
    op_d      = op_q;
    key_d     = key_q;
    handle_d  = handle_q;
    res_d     = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = {key_q, handle_q};

    unique case (state_q)
      kst_pkg::KST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = kst_pkg::op_e'(opcode_i);
          key_d    = key_id_i;
          handle_d = entry_handle_i;
          scan_d   = '0;
          res_d.status = kst_pkg::ST_OK;
          res_d.found  = 1'b0;
          res_d.key    = '0;
          res_d.handle = '0;
          res_d.count  = kst_pkg::CountW'(occ_q);
          if (kst_pkg::op_e'(opcode_i) == kst_pkg::OP_POP) begin
            if (occ_q == '0) begin
              res_d.status = kst_pkg::ST_EMPTY;
              state_d      = kst_pkg::KST_RESULT;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = last_w[AW-1:0];
              occ_d     = last_w;
              state_d   = kst_pkg::KST_POP_DATA;
            end
          end else begin
            state_d = kst_pkg::KST_SEARCH;
          end
        end
      end

      kst_pkg::KST_SEARCH: begin
        // one read issued and one compare done per cycle
        if (scan_q < occ_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = scan_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = scan_q[AW-1:0];
          scan_d    = scan_q + OW'(1);
        end
        if (hit) begin
          rd_vld_d     = 1'b0;
          res_d.found  = 1'b1;
          res_d.key    = rd_key;
          res_d.handle = rd_handle;
          slot_d       = rd_idx_q;
          unique case (op_q)
            kst_pkg::OP_ADD: begin
              res_d.status = kst_pkg::ST_ABSENT;
              state_d      = kst_pkg::KST_RESULT;
            end
            kst_pkg::OP_REMOVE: state_d = kst_pkg::KST_MOVE_RD;
            default:            state_d = kst_pkg::KST_RESULT;
          endcase
        end else if (miss) begin
          rd_vld_d = 1'b0;
          state_d  = kst_pkg::KST_RESULT;
          if (op_q == kst_pkg::OP_ADD) begin
            if (occ_q == OW'(Capacity)) begin
              res_d.status = kst_pkg::ST_FULL;
            end else begin
              wr_en_o     = 1'b1;
              wr_addr_o   = occ_q[AW-1:0];
              occ_d       = occ_q + OW'(1);
              res_d.count = kst_pkg::CountW'(occ_q + OW'(1));
            end
          end else begin
            res_d.status = kst_pkg::ST_ABSENT;
          end
        end
      end

      kst_pkg::KST_MOVE_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = last_w[AW-1:0];
        occ_d     = last_w;
        state_d   = kst_pkg::KST_MOVE_WR;
      end

      kst_pkg::KST_MOVE_WR: begin
        // last entry fills the hole; harmless when the hole is the last slot
        wr_en_o     = 1'b1;
        wr_addr_o   = slot_q;
        wr_data_o   = rd_data_i;
        res_d.count = kst_pkg::CountW'(occ_q);
        state_d     = kst_pkg::KST_RESULT;
      end

      kst_pkg::KST_POP_DATA: begin
        res_d.key    = rd_key;
        res_d.handle = rd_handle;
        res_d.count  = kst_pkg::CountW'(occ_q);
        state_d      = kst_pkg::KST_RESULT;
      end

      kst_pkg::KST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = kst_pkg::KST_IDLE;
        end
      end

      default: state_d = kst_pkg::KST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kst_pkg::KST_IDLE;
      occ_q    <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
    op_q     <= op_d;
    key_q    <= key_d;
    handle_q <= handle_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/keyed_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_set_table
// Packed set of key/handle entries with add, remove, get and pop.
// ----------------------------------------------------------------------------
// latency, accepted word to result word, grows with occupancy for add, get and remove,
// which scan the set; remove then moves the last entry into the hole; pop reads only the last entry
// one word at a time, the next accepted once the last result enters the output register;
// the scan reads one entry per cycle through the single read port, which sets the rate
// the output register holds a finished word while the next one is accepted
// reset empties the set at once; entry contents are not cleared
module keyed_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kst_pkg::OpW-1:0]     opcode_i,
  input  logic [kst_pkg::KeyW-1:0]    key_id_i,
  input  logic [kst_pkg::HandleW-1:0] entry_handle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kst_pkg::StatusW-1:0] status_o,
  output logic                        found_o,
  output logic [kst_pkg::KeyW-1:0]    out_key_o,
  output logic [kst_pkg::HandleW-1:0] out_handle_o,
  output logic [kst_pkg::CountW-1:0]  count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  kst_pkg::result_t           res;
  kst_pkg::result_t           out_q;
  logic                       res_valid;
  logic                       res_ready;
  logic                       out_valid_q;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [kst_pkg::EntryW-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [kst_pkg::EntryW-1:0] wr_data;

  kst_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .key_id_i       (key_id_i),
    .entry_handle_i (entry_handle_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  kst_mem #(
    .Depth (CAPACITY),
    .Width (kst_pkg::EntryW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // output word register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign found_o      = out_q.found;
  assign out_key_o    = out_q.key;
  assign out_handle_o = out_q.handle;
  assign count_o      = out_q.count;

endmodule

>>> test/keyed_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_set_table_tb
// Self-checking bench for the keyed set table. A directed opening covers the
// empty, duplicate, absent, move-on-remove and pop cases. Random phases follow
// with fills to capacity, grow, shrink and even mixes of operations, and with
// idle and stall patterns on both channels. A shadow copy of the set predicts
// every result word, and the monitor compares each result field by field.
// ----------------------------------------------------------------------------
module keyed_set_table_tb;

  localparam int unsigned SetCap       = 64;
  localparam int unsigned PoolSize     = 96;
  localparam int unsigned PhaseWords   = 250;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned DrainCycles  = 80;

  typedef struct packed {
    kst_pkg::op_e                op;
    logic [kst_pkg::KeyW-1:0]    key;
    logic [kst_pkg::HandleW-1:0] handle;
  } op_word_t;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_e;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid     = 1'b0;
  logic [kst_pkg::OpW-1:0]       opcode       = '0;
  logic [kst_pkg::KeyW-1:0]      key_id       = '0;
  logic [kst_pkg::HandleW-1:0]   entry_handle = '0;
  logic                          out_ready    = 1'b0;
  logic                          in_ready;
  logic                          out_valid;
  logic [kst_pkg::StatusW-1:0]   rsp_status;
  logic                          rsp_found;
  logic [kst_pkg::KeyW-1:0]      rsp_key;
  logic [kst_pkg::HandleW-1:0]   rsp_handle;
  logic [kst_pkg::CountW-1:0]    rsp_count;

  // stimulus side
  op_word_t                      send_q[$];
  op_word_t                      tx_word;
  logic [kst_pkg::KeyW-1:0]      key_pool[PoolSize];
  int unsigned                   send_idle_pct  = 0;
  int unsigned                   recv_stall_pct = 0;
  logic                          hold_arm       = 1'b0;
  logic                          rx_hold        = 1'b0;

  // shadow of the set and the results it predicts
  logic [kst_pkg::KeyW-1:0]      shadow_keys[SetCap];
  logic [kst_pkg::HandleW-1:0]   shadow_handles[SetCap];
  int                            shadow_count = 0;
  kst_pkg::result_t              due_results[$];
  kst_pkg::result_t              want_word;
  int                            errors = 0;

  keyed_set_table #(
    .CAPACITY(SetCap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .key_id_i      (key_id),
    .entry_handle_i(entry_handle),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (rsp_status),
    .found_o       (rsp_found),
    .out_key_o     (rsp_key),
    .out_handle_o  (rsp_handle),
    .count_o       (rsp_count)
  );

  always #5 clk_i = ~clk_i;

  // applies one operation to the shadow set and queues the result it gives
  function automatic void set_apply(kst_pkg::op_e op, logic [kst_pkg::KeyW-1:0] key,
                                    logic [kst_pkg::HandleW-1:0] hdl);
    kst_pkg::result_t r;
    int               slot;
    r        = '0;
    r.status = kst_pkg::ST_OK;
    slot     = -1;
    if (op != kst_pkg::OP_POP) begin
      for (int i = 0; i < shadow_count; i++) begin
        if (slot < 0 && shadow_keys[i] == key) slot = i;
      end
    end
    case (op)
      kst_pkg::OP_ADD: begin
        if (slot >= 0) begin
          r.status = kst_pkg::ST_ABSENT;
          r.found  = 1'b1;
          r.key    = shadow_keys[slot];
          r.handle = shadow_handles[slot];
        end else if (shadow_count >= SetCap) begin
          r.status = kst_pkg::ST_FULL;
        end else begin
          shadow_keys[shadow_count]    = key;
          shadow_handles[shadow_count] = hdl;
          shadow_count++;
        end
      end
      kst_pkg::OP_REMOVE, kst_pkg::OP_GET: begin
        if (slot >= 0) begin
          r.found  = 1'b1;
          r.key    = shadow_keys[slot];
          r.handle = shadow_handles[slot];
          if (op == kst_pkg::OP_REMOVE) begin
            // last entry fills the hole
            shadow_count--;
            shadow_keys[slot]    = shadow_keys[shadow_count];
            shadow_handles[slot] = shadow_handles[shadow_count];
          end
        end else begin
          r.status = kst_pkg::ST_ABSENT;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = kst_pkg::ST_EMPTY;
        end else begin
          shadow_count--;
          r.key    = shadow_keys[shadow_count];
          r.handle = shadow_handles[shadow_count];
        end
      end
    endcase
    r.count = kst_pkg::CountW'(shadow_count);
    due_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) set_apply(kst_pkg::op_e'(opcode), key_id, entry_handle);
      if (!in_valid || in_ready) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tx_word      = send_q.pop_front();
          in_valid     <= 1'b1;
          opcode       <= tx_word.op;
          key_id       <= tx_word.key;
          entry_handle <= tx_word.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          want_word = due_results.pop_front();
          check_field("status", 32'(want_word.status), 32'(rsp_status));
          check_field("found", 32'(want_word.found), 32'(rsp_found));
          check_field("out_key", 32'(want_word.key), 32'(rsp_key));
          check_field("out_handle", 32'(want_word.handle), 32'(rsp_handle));
          check_field("count", 32'(want_word.count), 32'(rsp_count));
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one long receiver hold-off so the block backs up and stalls its input
  initial begin : rx_hold_off
    while (!hold_arm) @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (RxHoldCycles) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL keyed_set_table");
    $finish;
  end

  function automatic void queue_word(kst_pkg::op_e op, logic [kst_pkg::KeyW-1:0] key,
                                     logic [kst_pkg::HandleW-1:0] hdl);
    op_word_t w;
    w.op     = op;
    w.key    = key;
    w.handle = hdl;
    send_q.push_back(w);
  endfunction

  function automatic logic [kst_pkg::KeyW-1:0] pick_key();
    if ($urandom_range(99) < 15) return kst_pkg::KeyW'($urandom);
    return key_pool[$urandom_range(PoolSize - 1)];
  endfunction

  function automatic logic [kst_pkg::HandleW-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return kst_pkg::HandleW'($urandom);
  endfunction

  // consecutive distinct pool keys, enough to reach capacity and overflow
  function automatic int queue_fill(int n);
    int unsigned base;
    base = $urandom_range(PoolSize - 1);
    for (int i = 0; i < n; i++) begin
      queue_word(kst_pkg::OP_ADD, key_pool[(base + i) % PoolSize], pick_handle());
    end
    return n;
  endfunction

  function automatic int queue_burst(mix_e mix, int n);
    int unsigned  roll;
    kst_pkg::op_e op;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      case (mix)
        MIX_GROW:   op = roll < 70 ? kst_pkg::OP_ADD : roll < 80 ? kst_pkg::OP_GET :
                         roll < 92 ? kst_pkg::OP_REMOVE : kst_pkg::OP_POP;
        MIX_SHRINK: op = roll < 10 ? kst_pkg::OP_ADD : roll < 25 ? kst_pkg::OP_GET :
                         roll < 65 ? kst_pkg::OP_REMOVE : kst_pkg::OP_POP;
        default:    op = kst_pkg::op_e'(roll % 4);
      endcase
      // now and then swap in a new key so stale entries linger
      if ($urandom_range(99) < 2) begin
        key_pool[$urandom_range(PoolSize - 1, 2)] = kst_pkg::KeyW'($urandom);
      end
      queue_word(op, pick_key(), pick_handle());
    end
    return n;
  endfunction

  task automatic wait_all_done();
    while (send_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int queued;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = kst_pkg::KeyW'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed opening
    queue_word(kst_pkg::OP_POP,    '1,             16'hFFFF);
    queue_word(kst_pkg::OP_GET,    '0,             16'h0000);
    queue_word(kst_pkg::OP_REMOVE, '1,             16'h0000);
    queue_word(kst_pkg::OP_ADD,    '0,             16'h0000);
    queue_word(kst_pkg::OP_ADD,    '1,             16'hFFFF);
    queue_word(kst_pkg::OP_ADD,    '0,             16'h1234);
    queue_word(kst_pkg::OP_ADD,    31'h2AAA_AAAA,  16'hA5A5);
    queue_word(kst_pkg::OP_ADD,    31'h5555_5555,  16'h5A5A);
    queue_word(kst_pkg::OP_GET,    '1,             16'h0000);
    queue_word(kst_pkg::OP_GET,    31'h1234_5678,  16'hFFFF);
    queue_word(kst_pkg::OP_REMOVE, '0,             16'h0000);
    queue_word(kst_pkg::OP_GET,    31'h5555_5555,  16'h0000);
    queue_word(kst_pkg::OP_REMOVE, 31'h5555_5555,  16'h0000);
    queue_word(kst_pkg::OP_REMOVE, 31'h5555_5555,  16'h0000);
    queue_word(kst_pkg::OP_GET,    31'h2AAA_AAAA,  16'h0000);
    queue_word(kst_pkg::OP_POP,    '0,             16'h0000);
    queue_word(kst_pkg::OP_POP,    31'h2AAA_AAAA,  16'h0000);
    queue_word(kst_pkg::OP_POP,    31'h5555_5555,  16'hFFFF);
    queue_word(kst_pkg::OP_ADD,    31'h0000_0001,  16'h0001);
    queue_word(kst_pkg::OP_POP,    '1,             16'h0000);
    wait_all_done();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      queued = queue_fill(SetCap + 6);
      while (queued < PhaseWords) begin
        queued += queue_burst(mix_e'($urandom_range(2)), $urandom_range(60, 20));
      end
      if (ph == 0) hold_arm = 1'b1;
      // sender pauses here until every word of the phase has come back
      wait_all_done();
    end

    recv_stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d result words never arrived", due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS keyed_set_table");
    end else begin
      $display("FAIL keyed_set_table");
    end
    $finish;
  end

endmodule

>>> keyed_set_table.f
rtl/core/kst_pkg.sv
rtl/core/kst_mem.sv
rtl/core/kst_ctrl.sv
rtl/core/keyed_set_table.sv
test/keyed_set_table_tb.sv
